/* design/xht_pkg.sv */
// ----------------------------------------------------------------------------
// xht_pkg: shared types and constants of the extended-memory handle table
// Holds the call and error codes, the beat types of both channels and the
// slot table write port type.
// ----------------------------------------------------------------------------
package xht_pkg;

  // Table geometry.
  localparam int SLOTS  = 10;
  localparam int SIZE_W = 26;

  // Call codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_VERSION = 3'd0,
    ACT_QUERY   = 3'd1,
    ACT_ALLOC   = 3'd2,
    ACT_FREE    = 3'd3,
    ACT_LOCK    = 3'd4,
    ACT_UNLOCK  = 3'd5,
    ACT_MOVE    = 3'd6,
    ACT_UNKNOWN = 3'd7
  } act_t;

  // Error codes reported with each result.
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_NO_HANDLE = 3'd1;
  localparam logic [2:0] ERR_BAD_HND   = 3'd2;
  localparam logic [2:0] ERR_BAD_SH    = 3'd3;
  localparam logic [2:0] ERR_BAD_SO    = 3'd4;
  localparam logic [2:0] ERR_BAD_DH    = 3'd5;
  localparam logic [2:0] ERR_BAD_DO    = 3'd6;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd7;

  // Fixed result words of the driver interface.
  localparam logic [15:0] VERSION_AX  = 16'h0300;
  localparam logic [15:0] VERSION_BX  = 16'h0301;
  localparam logic [15:0] QUERY_AX    = 16'h0500;
  localparam logic [15:0] QUERY_DX    = 16'h4000;
  localparam logic [15:0] XERR_NO_HND = 16'h00A1;
  localparam logic [15:0] XERR_HND    = 16'h00A2;
  localparam logic [15:0] XERR_SH     = 16'h00A3;
  localparam logic [15:0] XERR_SO     = 16'h00A4;
  localparam logic [15:0] XERR_DH     = 16'h00A5;
  localparam logic [15:0] XERR_DO     = 16'h00A6;

  // One request beat.
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] dx_in;
    logic [15:0] bx_in;
    logic [31:0] move_length;
    logic [15:0] src_handle;
    logic [31:0] src_offset;
    logic [15:0] dst_handle;
    logic [31:0] dst_offset;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] ax_out;
    logic [15:0] bx_out;
    logic [15:0] dx_out;
    logic [2:0]  error_code;
    logic        move_go;
  } rsp_t;

  // Slot table contents and its single write port.
  typedef logic [SLOTS-1:0][SIZE_W-1:0] slot_arr_t;

  typedef struct packed {
    logic             en;
    logic [SLOTS-1:0] sel;
    logic [SIZE_W-1:0] size;
  } slot_wr_t;

endpackage

/* design/xms_handle_table.sv */
// ----------------------------------------------------------------------------
// xms_handle_table: extended-memory handle manager
// Serves extended-memory driver calls against a small table of handle slots
// and returns the AX, BX and DX words, an error code and a move go flag.
// ----------------------------------------------------------------------------
// Use of the block:
//   A request beat is taken on in_data at each rising edge with start high
//   and busy low. busy stays low, so a request may be given every cycle.
//   The request is registered, decoded and checked against the slot table in
//   the following cycle, and the result beat is registered at the end of it.
//   out_strobe is high for exactly one cycle with the result on out_data,
//   starting at the edge after the request edge, and the result beat is
//   taken at the edge that ends the strobe pulse; the receiver cannot
//   stall, so every result must be taken in that cycle.
//   Throughput is one call per cycle. The slot table is updated at the same
//   edge that registers the result, so a call always sees the effect of the
//   call just before it.
//   Synchronous reset clears every slot to free and drops any call in flight.
// ----------------------------------------------------------------------------
module xms_handle_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  xht_pkg::req_t  in_data,
  output logic           out_strobe,
  output xht_pkg::rsp_t  out_data
);

  xht_pkg::req_t      req_r;
  logic               vld_r;
  xht_pkg::rsp_t      rsp_nxt;
  xht_pkg::rsp_t      rsp_r;
  logic               strobe_r;
  xht_pkg::slot_wr_t  wr;
  xht_pkg::slot_arr_t slots;

  assign busy = 1'b0;

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_data;
    end
  end

  // Slot table and call logic.
  xht_slots u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .slots (slots)
  );

  xht_exec u_exec (
    .req     (req_r),
    .req_vld (vld_r),
    .slots   (slots),
    .rsp     (rsp_nxt),
    .wr      (wr)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = rsp_r;

endmodule

/* design/xht_slots.sv */
// ----------------------------------------------------------------------------
// xht_slots: handle slot table
// One size register per handle slot, cleared at reset, written through a
// one-hot select. A size of zero marks a free slot.
// ----------------------------------------------------------------------------
module xht_slots (
  input  logic                clk,
  input  logic                rst_n,
  input  xht_pkg::slot_wr_t   wr,
  output xht_pkg::slot_arr_t  slots
);

  xht_pkg::slot_arr_t slot_r;
  xht_pkg::slot_arr_t slot_nxt;

  // Apply the write to the selected slot only.
  always_comb begin
    slot_nxt = slot_r;
    for (int i = 0; i < xht_pkg::SLOTS; i++) begin
      if (wr.en && wr.sel[i]) begin
        slot_nxt[i] = wr.size;
      end
    end
  end

  // Every slot starts free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slots = slot_r;

endmodule

/* design/xht_exec.sv */
// ----------------------------------------------------------------------------
// xht_exec: call decode and checks
// Works out the result words of one call from the registered request and
// the slot table, and the slot write that the call makes.
// ----------------------------------------------------------------------------
module xht_exec (
  input  xht_pkg::req_t       req,
  input  logic                req_vld,
  input  xht_pkg::slot_arr_t  slots,
  output xht_pkg::rsp_t       rsp,
  output xht_pkg::slot_wr_t   wr
);

  logic [xht_pkg::SLOTS-1:0]  occ;
  logic [xht_pkg::SLOTS-1:0]  free_v;
  logic [xht_pkg::SLOTS-1:0]  first_free;
  logic [xht_pkg::SLOTS-1:0]  dx_sel;
  logic [xht_pkg::SLOTS-1:0]  sh_sel;
  logic [xht_pkg::SLOTS-1:0]  dh_sel;
  logic [15:0]                alloc_hnd;
  logic [xht_pkg::SIZE_W-1:0] sh_size;
  logic [xht_pkg::SIZE_W-1:0] dh_size;
  logic                       dx_ok;
  logic                       sh_ok;
  logic                       dh_ok;
  logic [32:0]                src_end;
  logic [32:0]                dst_end;
  logic                       src_fit;
  logic                       dst_fit;

  // Per-slot decode of the three handles and of the occupancy.
  always_comb begin
    alloc_hnd = '0;
    sh_size   = '0;
    dh_size   = '0;
    for (int i = 0; i < xht_pkg::SLOTS; i++) begin
      occ[i]    = (slots[i] != '0);
      dx_sel[i] = (req.dx_in == 16'(i + 1));
      sh_sel[i] = (req.src_handle == 16'(i + 1));
      dh_sel[i] = (req.dst_handle == 16'(i + 1));
    end
    free_v     = ~occ;
    first_free = free_v & (~free_v + xht_pkg::SLOTS'(1));
    for (int i = 0; i < xht_pkg::SLOTS; i++) begin
      if (first_free[i]) begin
        alloc_hnd = alloc_hnd | 16'(i + 1);
      end
      if (sh_sel[i]) begin
        sh_size = sh_size | slots[i];
      end
      if (dh_sel[i]) begin
        dh_size = dh_size | slots[i];
      end
    end
  end

  assign dx_ok = |(dx_sel & occ);
  assign sh_ok = |(sh_sel & occ);
  assign dh_ok = |(dh_sel & occ);

  // Block end checks, summed one bit wider so that nothing wraps.
  assign src_end = {1'b0, req.src_offset} + {1'b0, req.move_length};
  assign dst_end = {1'b0, req.dst_offset} + {1'b0, req.move_length};
  assign src_fit = (src_end <= 33'(sh_size));
  assign dst_fit = (dst_end <= 33'(dh_size));

  // Result words and table write for each call.
  always_comb begin
    rsp.ax_out     = '0;
    rsp.bx_out     = req.bx_in;
    rsp.dx_out     = req.dx_in;
    rsp.error_code = xht_pkg::ERR_OK;
    rsp.move_go    = 1'b0;
    wr.en          = 1'b0;
    wr.sel         = '0;
    wr.size        = '0;
    case (xht_pkg::act_t'(req.action))
      xht_pkg::ACT_VERSION: begin
        rsp.ax_out = xht_pkg::VERSION_AX;
        rsp.bx_out = xht_pkg::VERSION_BX;
        rsp.dx_out = '0;
      end
      xht_pkg::ACT_QUERY: begin
        rsp.ax_out = xht_pkg::QUERY_AX;
        rsp.bx_out = '0;
        rsp.dx_out = xht_pkg::QUERY_DX;
      end
      xht_pkg::ACT_ALLOC: begin
        if (|free_v) begin
          rsp.ax_out = 16'd1;
          rsp.bx_out = '0;
          rsp.dx_out = alloc_hnd;
          wr.en      = req_vld;
          wr.sel     = first_free;
          wr.size    = {req.dx_in, 10'b0};
        end else begin
          rsp.bx_out     = xht_pkg::XERR_NO_HND;
          rsp.error_code = xht_pkg::ERR_NO_HANDLE;
        end
      end
      xht_pkg::ACT_FREE, xht_pkg::ACT_LOCK, xht_pkg::ACT_UNLOCK: begin
        if (!dx_ok) begin
          rsp.bx_out     = xht_pkg::XERR_HND;
          rsp.error_code = xht_pkg::ERR_BAD_HND;
        end else begin
          rsp.ax_out = 16'd1;
          if (xht_pkg::act_t'(req.action) == xht_pkg::ACT_FREE) begin
            wr.en  = req_vld;
            wr.sel = dx_sel;
          end else if (xht_pkg::act_t'(req.action) == xht_pkg::ACT_LOCK) begin
            rsp.bx_out = '0;
            rsp.dx_out = {req.dx_in[11:0], 4'b0};
          end
        end
      end
      xht_pkg::ACT_MOVE: begin
        // Source first, then destination; handle zero skips its checks.
        rsp.bx_out = '0;
        if (req.src_handle != '0 && !sh_ok) begin
          rsp.bx_out     = xht_pkg::XERR_SH;
          rsp.error_code = xht_pkg::ERR_BAD_SH;
        end else if (req.src_handle != '0 && !src_fit) begin
          rsp.bx_out     = xht_pkg::XERR_SO;
          rsp.error_code = xht_pkg::ERR_BAD_SO;
        end else if (req.dst_handle != '0 && !dh_ok) begin
          rsp.bx_out     = xht_pkg::XERR_DH;
          rsp.error_code = xht_pkg::ERR_BAD_DH;
        end else if (req.dst_handle != '0 && !dst_fit) begin
          rsp.bx_out     = xht_pkg::XERR_DO;
          rsp.error_code = xht_pkg::ERR_BAD_DO;
        end else begin
          rsp.ax_out  = 16'd1;
          rsp.move_go = 1'b1;
        end
      end
      default: begin
        rsp.error_code = xht_pkg::ERR_UNKNOWN;
      end
    endcase
  end

endmodule
